[sv/multi_pattern_byte_matcher_assert.svh]
// Assertion macros for the multi-pattern byte matcher.
// Included by the top level; needs nothing else.
`ifndef MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger
`define MPBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mpbm: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger
`define MPBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mpbm: next-cycle check failed");

`endif

[sv/mpbm_pkg.sv]
// Shared types and constants of the multi-pattern byte matcher.
// No dependencies; the interfaces and the top level import it.
`default_nettype none

package mpbm_pkg;

	// Parameter defaults
	localparam int NODE_COUNT_DEF           = 1024;
	localparam int ALPHABET_SIZE_DEF        = 256;
	localparam int MATCH_ENTRIES_DEF        = 1024;
	localparam int MAX_RESULTS_PER_BYTE_DEF = 16;

	// Fixed field widths of the channels
	localparam int CMD_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int NODE_W  = 10;
	localparam int ENTRY_W = 10;
	localparam int LEN_W   = 9;
	localparam int KIND_W  = 8;
	localparam int POS_W   = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_SCAN        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE_GOTO  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE_NODE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE_MATCH = 3'd4;

	// Sequencer states
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_WALK  = 6'b000100,
		ST_HEAD  = 6'b001000,
		ST_MATCH = 6'b010000,
		ST_DRAIN = 6'b100000
	} state_t;

	// One collected match, waiting to be delivered
	typedef struct packed {
		logic [ENTRY_W-1:0] entry;
		logic [LEN_W-1:0]   length;
		logic [KIND_W-1:0]  kind;
	} hit_t;

endpackage

`default_nettype wire

[sv/mpbm_if.sv]
// Valid/ready channel interfaces of the multi-pattern byte matcher.
// Depends on mpbm_pkg for the field widths.
`default_nettype none

interface mpbm_item_if
	import mpbm_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [BYTE_W-1:0]  data_byte;
	logic [NODE_W-1:0]  node_id;
	logic [NODE_W-1:0]  link_node;
	logic [ENTRY_W-1:0] match_id;
	logic               match_valid;
	logic [ENTRY_W-1:0] next_match_id;
	logic [LEN_W-1:0]   pattern_length;
	logic [KIND_W-1:0]  pattern_type;

	modport source (
		output valid, command, data_byte, node_id, link_node, match_id,
		       match_valid, next_match_id, pattern_length, pattern_type,
		input  ready
	);
	modport sink (
		input  valid, command, data_byte, node_id, link_node, match_id,
		       match_valid, next_match_id, pattern_length, pattern_type,
		output ready
	);
endinterface

interface mpbm_result_if
	import mpbm_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   start_position;
	logic [ENTRY_W-1:0] matched_entry;
	logic [KIND_W-1:0]  matched_type;
	logic               last;
	logic               overflow;

	modport source (
		output valid, start_position, matched_entry, matched_type, last, overflow,
		input  ready
	);
	modport sink (
		input  valid, start_position, matched_entry, matched_type, last, overflow,
		output ready
	);
endinterface

`default_nettype wire

[sv/mpbm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mpbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[sv/multi_pattern_byte_matcher.sv]
// Top level of the multi-pattern byte matcher (Aho-Corasick automaton walker).
// Depends on mpbm_pkg, mpbm_if, mpbm_ram and multi_pattern_byte_matcher_assert.svh.
//
// After reset the block clears its goto, failure and match-head tables, one goto
// entry per cycle; ready stays low meanwhile. Each transaction on the item channel
// is then a command. A scanned byte first reads the goto table, following failure
// links while the child is missing, then reads the match-list head of the new node,
// then reads the entries of that node's match list (at most MAX_RESULTS_PER_BYTE)
// and last delivers the results (one per cycle while the sink keeps up); a byte
// that lands on a node with no matches skips the list and the delivery, and a walk
// cut at its bound goes back to the root. Each table has a single read port: every
// failure step is one goto read, every list entry one match read. Results of a byte
// are gathered first and then delivered with overflow already known; the next item
// is accepted while the final result still waits.
`default_nettype none
`include "multi_pattern_byte_matcher_assert.svh"

module multi_pattern_byte_matcher
	import mpbm_pkg::*;
#(
	parameter int NODE_COUNT           = NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE        = ALPHABET_SIZE_DEF,
	parameter int MATCH_ENTRIES        = MATCH_ENTRIES_DEF,
	parameter int MAX_RESULTS_PER_BYTE = MAX_RESULTS_PER_BYTE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mpbm_item_if.sink     item,
	mpbm_result_if.source result
);

	localparam int NW  = $clog2(NODE_COUNT);
	localparam int GD  = NODE_COUNT * ALPHABET_SIZE;
	localparam int GW  = $clog2(GD);
	localparam int MW  = (MATCH_ENTRIES > 1) ? $clog2(MATCH_ENTRIES) : 1;
	localparam int MTW = LEN_W + KIND_W + 1 + MW;
	localparam int SW  = $clog2(NODE_COUNT + 1);
	localparam int CW  = $clog2(MAX_RESULTS_PER_BYTE + 1);
	localparam int BW  = (MAX_RESULTS_PER_BYTE > 1) ? $clog2(MAX_RESULTS_PER_BYTE) : 1;

	// Goto table address of a node and a byte
	function automatic logic [GW-1:0] goto_addr(input logic [NW-1:0] node,
			input logic [BYTE_W-1:0] byte_val);
		return GW'(32'(node) * 32'(ALPHABET_SIZE) + 32'(byte_val));
	endfunction

	state_t            state_q;
	logic [GW-1:0]     clr_q;
	logic [NW-1:0]     cur_node_q;
	logic [NW-1:0]     walk_q;
	logic [BYTE_W-1:0] byte_q;
	logic [SW-1:0]     steps_q;
	logic [POS_W-1:0]  pos_q;
	logic [MW-1:0]     mi_q;
	logic [CW-1:0]     cnt_q;
	logic [BW-1:0]     rd_q;
	logic              cut_q;
	hit_t              buf_q [MAX_RESULTS_PER_BYTE];

	logic               out_valid_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [ENTRY_W-1:0] out_entry_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic               out_last_q;
	logic               out_ovf_q;

	// Table ports
	logic          g_we;
	logic [GW-1:0] g_waddr, g_raddr;
	logic [NW-1:0] g_wdata, g_rdata;
	logic          f_we;
	logic [NW-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
	logic          h_we;
	logic [NW-1:0] h_waddr, h_raddr;
	logic [MW:0]   h_wdata, h_rdata;
	logic          m_we;
	logic [MW-1:0] m_waddr, m_raddr;
	logic [MTW-1:0] m_wdata, m_rdata;

	logic accept;
	logic byte_ok, node_ok, link_ok, mid_ok, nxt_ok;
	logic clr_in_nodes;
	logic walk_bound;
	logic m_next_valid;
	logic [MW-1:0] m_next;
	logic [KIND_W-1:0] m_kind;
	logic [LEN_W-1:0]  m_len;
	logic out_load, out_final;
	logic cnt_full_next;
	hit_t hit;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid & item.ready;

	// Range checks on the incoming operands
	assign byte_ok = 32'(item.data_byte) < ALPHABET_SIZE;
	assign node_ok = 32'(item.node_id) < NODE_COUNT;
	assign link_ok = 32'(item.link_node) < NODE_COUNT;
	assign mid_ok  = 32'(item.match_id) < MATCH_ENTRIES;
	assign nxt_ok  = 32'(item.next_match_id) < MATCH_ENTRIES;

	assign clr_in_nodes = 32'(clr_q) < NODE_COUNT;
	assign walk_bound   = 32'(steps_q) >= NODE_COUNT;

	// Unpack the match entry read back
	assign m_next       = m_rdata[MW-1:0];
	assign m_next_valid = m_rdata[MW];
	assign m_kind       = m_rdata[MW+KIND_W:MW+1];
	assign m_len        = m_rdata[MTW-1:MW+KIND_W+1];

	assign hit = '{entry: ENTRY_W'(mi_q), length: m_len, kind: m_kind};
	assign cnt_full_next = (cnt_q + CW'(1)) == CW'(MAX_RESULTS_PER_BYTE);

	assign out_load  = (state_q == ST_DRAIN) && (!out_valid_q || result.ready);
	assign out_final = out_load && ((CW'(rd_q) + CW'(1)) == cnt_q);

	// Steer the table ports
	always_comb begin
		g_we    = 1'b0;
		g_waddr = clr_q;
		g_wdata = '0;
		g_raddr = goto_addr(cur_node_q, item.data_byte);
		f_we    = 1'b0;
		f_waddr = clr_q[NW-1:0];
		f_wdata = '0;
		f_raddr = cur_node_q;
		h_we    = 1'b0;
		h_waddr = clr_q[NW-1:0];
		h_wdata = '0;
		h_raddr = '0;
		m_we    = 1'b0;
		m_waddr = MW'(item.match_id);
		m_wdata = {item.pattern_length, item.pattern_type, item.match_valid,
			item.match_valid ? MW'(item.next_match_id) : MW'(0)};
		m_raddr = h_rdata[MW-1:0];
		case (state_q)
			ST_CLEAR: begin
				g_we = 1'b1;
				f_we = clr_in_nodes;
				h_we = clr_in_nodes;
			end
			ST_IDLE: begin
				if (accept) begin
					case (item.command)
						CMD_WRITE_GOTO: begin
							g_we    = node_ok && link_ok && byte_ok;
							g_waddr = goto_addr(NW'(item.node_id), item.data_byte);
							g_wdata = NW'(item.link_node);
						end
						CMD_WRITE_NODE: begin
							f_we    = node_ok && link_ok && !(item.match_valid && !mid_ok);
							h_we    = f_we;
							f_waddr = NW'(item.node_id);
							h_waddr = NW'(item.node_id);
							f_wdata = NW'(item.link_node);
							h_wdata = {item.match_valid,
								item.match_valid ? MW'(item.match_id) : MW'(0)};
						end
						CMD_WRITE_MATCH: begin
							m_we = mid_ok && !(item.match_valid && !nxt_ok);
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (g_rdata != '0) begin
					h_raddr = g_rdata;
				end else if (walk_q == '0) begin
					h_raddr = '0;
				end else if (walk_bound) begin
					g_raddr = goto_addr('0, byte_q);
				end else begin
					g_raddr = goto_addr(f_rdata, byte_q);
					f_raddr = f_rdata;
				end
			end
			ST_MATCH: begin
				m_raddr = m_next;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cur_node_q  <= '0;
			walk_q      <= '0;
			steps_q     <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			rd_q        <= '0;
			cut_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a result, or drop one that has been taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + GW'(1);
					if (clr_q == GW'(GD - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (item.command)
							CMD_SCAN: begin
								walk_q  <= cur_node_q;
								steps_q <= '0;
								cnt_q   <= '0;
								cut_q   <= 1'b0;
								if (byte_ok) begin
									state_q <= ST_WALK;
								end else begin
									cur_node_q <= '0;
									state_q    <= ST_HEAD;
								end
							end
							CMD_START: begin
								cur_node_q <= '0;
								pos_q      <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (g_rdata != '0) begin
						cur_node_q <= g_rdata;
						state_q    <= ST_HEAD;
					end else if (walk_q == '0) begin
						cur_node_q <= '0;
						state_q    <= ST_HEAD;
					end else if (walk_bound) begin
						walk_q <= '0;
					end else begin
						walk_q  <= f_rdata;
						steps_q <= steps_q + SW'(1);
					end
				end
				ST_HEAD: begin
					if (h_rdata[MW]) begin
						state_q <= ST_MATCH;
					end else begin
						pos_q   <= pos_q + POS_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_MATCH: begin
					cnt_q <= cnt_q + CW'(1);
					rd_q  <= '0;
					if (!m_next_valid) begin
						state_q <= ST_DRAIN;
					end else if (cnt_full_next) begin
						cut_q   <= 1'b1;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						rd_q <= rd_q + BW'(1);
					end
					if (out_final) begin
						pos_q   <= pos_q + POS_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: scan byte, list pointer, gathered hits, result
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= item.data_byte;
		end
		if (state_q == ST_HEAD) begin
			mi_q <= h_rdata[MW-1:0];
		end else if (state_q == ST_MATCH) begin
			mi_q <= m_next;
		end
		if (state_q == ST_MATCH) begin
			buf_q[cnt_q[BW-1:0]] <= hit;
		end
		if (out_load) begin
			out_pos_q   <= pos_q - POS_W'(buf_q[rd_q].length) + POS_W'(1);
			out_entry_q <= buf_q[rd_q].entry;
			out_kind_q  <= buf_q[rd_q].kind;
			out_last_q  <= (CW'(rd_q) + CW'(1)) == cnt_q;
			out_ovf_q   <= cut_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.start_position = out_pos_q;
	assign result.matched_entry  = out_entry_q;
	assign result.matched_type   = out_kind_q;
	assign result.last           = out_last_q;
	assign result.overflow       = out_ovf_q;

	// Goto table: node and byte to child
	mpbm_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	// Failure links
	mpbm_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	// Match list heads: valid bit and first entry
	mpbm_ram #(.WIDTH(MW + 1), .DEPTH(NODE_COUNT)) u_head (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	// Match entries: length, type, next link
	mpbm_ram #(.WIDTH(MTW), .DEPTH(MATCH_ENTRIES)) u_match (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	// Delivery never runs past the gathered hits
	`MPBM_ASSERT_IMPL(a_drain_index, clk, arst_n, state_q == ST_DRAIN, CW'(rd_q) < cnt_q)
	// A cut list has filled the whole buffer
	`MPBM_ASSERT_IMPL(a_cut_full, clk, arst_n, (state_q == ST_DRAIN) && cut_q,
		cnt_q == CW'(MAX_RESULTS_PER_BYTE))
	// The failure walk stays within its bound
	`MPBM_ASSERT_IMPL(a_walk_bound, clk, arst_n, state_q == ST_WALK,
		32'(steps_q) <= NODE_COUNT)
	// The final result of a byte is shown flagged and the block is idle again
	`MPBM_ASSERT_NEXT(a_final_idle, clk, arst_n, out_final,
		(state_q == ST_IDLE) && out_valid_q && result.last)

endmodule

`default_nettype wire
